FILE: src/uvsg_pkg.sv
`timescale 1ns / 1ps
package uvsg_pkg;

   localparam int COUNT_W        = 8;
   localparam int MAX_SEGMENTS   = 255;
   localparam int UNIT_FRAC_BITS = 15;
   localparam int DIV_STAGES     = 40;
   localparam int CORDIC_STEPS   = 30;
   localparam int CORDIC_XY_W    = 34;
   localparam int CORDIC_Z_W     = 33;
   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_START = 34'sd652032874;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_SLICES = 2'd1;
   localparam logic [1:0] REG_STACKS = 2'd2;

   // atan(2^-k) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
   };

   typedef struct packed {
      logic [15:0] radius;
      logic [7:0]  slices;
      logic [7:0]  stacks;
   } cfg_type;

   typedef struct packed {
      logic [15:0] k;
      logic [8:0]  w;
      logic        quad;
   } side_type;

   typedef struct packed {
      logic [31:0] phi;
      logic [31:0] theta;
      side_type    side;
   } item_type;

   typedef struct packed {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic [15:0]        vertex_number;
      logic               quad_valid;
      logic [15:0]        tri_one_a;
      logic [15:0]        tri_one_b;
      logic [15:0]        tri_one_c;
      logic [15:0]        tri_two_a;
      logic [15:0]        tri_two_b;
      logic [15:0]        tri_two_c;
   } rsp_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
      if (c == '0) begin
         return COUNT_W'(1);
      end else if (int'(c) > MAX_SEGMENTS) begin
         return COUNT_W'(MAX_SEGMENTS);
      end else begin
         return c;
      end
   endfunction

endpackage

FILE: src/uvsg_angle_div.sv
`timescale 1ns / 1ps
module uvsg_angle_div (
   input  logic        clock,
   input  logic        en,
   input  logic [7:0]  num,
   input  logic [8:0]  den,
   output logic [31:0] quot
);
   localparam int N = uvsg_pkg::DIV_STAGES;

   logic [8:0]   rem_ff  [N];
   logic [8:0]   rem_in  [N];
   logic [N-1:0] dvd_ff  [N];
   logic [N-1:0] dvd_in  [N];
   logic [31:0]  quot_ff [N];
   logic [31:0]  quot_in [N];

   // restoring long division, one quotient bit per stage
   always_comb begin
      logic [8:0]   r;
      logic [N-1:0] d;
      logic [31:0]  q;
      logic [9:0]   t;
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            r = '0;
            d = {num, 24'b0, den[8:1]};
            q = '0;
         end else begin
            r = rem_ff[s-1];
            d = dvd_ff[s-1];
            q = quot_ff[s-1];
         end
         t = {r, d[N-1]};
         if (t >= {1'b0, den}) begin
            rem_in[s]  = 9'(t - {1'b0, den});
            quot_in[s] = {q[30:0], 1'b1};
         end else begin
            rem_in[s]  = t[8:0];
            quot_in[s] = {q[30:0], 1'b0};
         end
         dvd_in[s] = {d[N-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff[N-1];
endmodule

FILE: src/uvsg_front.sv
`timescale 1ns / 1ps
module uvsg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [7:0]         stack_index,
   input  logic [7:0]         slice_index,
   input  uvsg_pkg::cfg_type  cfg,
   output logic               out_valid,
   output uvsg_pkg::item_type out_item
);
   localparam int N = uvsg_pkg::DIV_STAGES;

   logic [7:0]          sl;
   logic [7:0]          st;
   uvsg_pkg::side_type  side_in;
   logic [31:0]         phi;
   logic [31:0]         theta;
   logic [N-1:0]        vld_ff;
   uvsg_pkg::side_type  side_ff [N];

   assign sl = uvsg_pkg::eff_count(cfg.slices);
   assign st = uvsg_pkg::eff_count(cfg.stacks);

   always_comb begin
      side_in.w    = 9'({1'b0, sl} + 9'd1);
      side_in.k    = 16'(17'(stack_index) * 17'(side_in.w) + 17'(slice_index));
      side_in.quad = (stack_index < st) && (slice_index < sl);
   end

   uvsg_angle_div u_phi_div (
      .clock (clock),
      .en    (en),
      .num   (stack_index),
      .den   ({st, 1'b0}),
      .quot  (phi)
   );

   uvsg_angle_div u_theta_div (
      .clock (clock),
      .en    (en),
      .num   (slice_index),
      .den   ({1'b0, sl}),
      .quot  (theta)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < N; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_item  = '{phi: phi, theta: theta, side: side_ff[N-1]};
endmodule

FILE: src/uvsg_queue.sv
`timescale 1ns / 1ps
module uvsg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  uvsg_pkg::item_type push_item,
   input  logic               pop,
   output uvsg_pkg::item_type head,
   output logic               not_empty,
   output logic               has_space
);
   localparam int D  = uvsg_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);

   uvsg_pkg::item_type mem_ff [D];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW:0]        count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= AW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= AW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= (AW+1)'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= (AW+1)'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign has_space = (count_ff < (AW+1)'(D));
endmodule

FILE: src/uvsg_cordic.sv
`timescale 1ns / 1ps
module uvsg_cordic #(
   parameter int FRAC = uvsg_pkg::UNIT_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [31:0]          angle,
   output logic signed [FRAC+1:0] sin_out,
   output logic signed [FRAC+1:0] cos_out
);
   localparam int STEPS = uvsg_pkg::CORDIC_STEPS;
   localparam int XW    = uvsg_pkg::CORDIC_XY_W;
   localparam int ZW    = uvsg_pkg::CORDIC_Z_W;
   localparam int U     = FRAC + 2;
   localparam int SH    = 30 - FRAC;

   logic signed [XW-1:0] x_ff [STEPS];
   logic signed [XW-1:0] x_in [STEPS];
   logic signed [XW-1:0] y_ff [STEPS];
   logic signed [XW-1:0] y_in [STEPS];
   logic signed [ZW-1:0] z_ff [STEPS];
   logic signed [ZW-1:0] z_in [STEPS];
   logic [1:0]           q_ff [STEPS];
   logic [1:0]           q_in [STEPS];
   logic signed [U-1:0]  sin_ff;
   logic signed [U-1:0]  sin_in;
   logic signed [U-1:0]  cos_ff;
   logic signed [U-1:0]  cos_in;

   // round to Q1.FRAC with ties away from zero, clamp to +-1
   function automatic logic signed [U-1:0] to_unit(input logic signed [XW-1:0] v);
      logic [XW:0] mag;
      logic [XW:0] m;
      mag = v[XW-1] ? (XW+1)'(-{v[XW-1], v}) : {1'b0, v};
      m   = (XW+1)'((mag + (XW+1)'(1 << (SH - 1))) >> SH);
      if (m > (XW+1)'(1 << FRAC)) begin
         m = (XW+1)'(1 << FRAC);
      end
      return v[XW-1] ? U'(-m) : U'(m);
   endfunction

   always_comb begin
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0]           q;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            x = uvsg_pkg::CORDIC_START;
            y = '0;
            z = ZW'({3'b0, angle[29:0]});
            q = angle[31:30];
         end else begin
            x = x_ff[s-1];
            y = y_ff[s-1];
            z = z_ff[s-1];
            q = q_ff[s-1];
         end
         if (!z[ZW-1]) begin
            x_in[s] = x - (y >>> s);
            y_in[s] = y + (x >>> s);
            z_in[s] = z - ZW'(uvsg_pkg::ATAN_TURN[s]);
         end else begin
            x_in[s] = x + (y >>> s);
            y_in[s] = y - (x >>> s);
            z_in[s] = z + ZW'(uvsg_pkg::ATAN_TURN[s]);
         end
         q_in[s] = q;
      end
   end

   always_comb begin
      logic signed [XW-1:0] xl;
      logic signed [XW-1:0] yl;
      logic signed [XW-1:0] c;
      logic signed [XW-1:0] sn;
      xl = x_ff[STEPS-1];
      yl = y_ff[STEPS-1];
      case (q_ff[STEPS-1])
         2'd0: begin
            c  = xl;
            sn = yl;
         end
         2'd1: begin
            c  = -yl;
            sn = xl;
         end
         2'd2: begin
            c  = -xl;
            sn = -yl;
         end
         default: begin
            c  = yl;
            sn = -xl;
         end
      endcase
      sin_in = to_unit(sn);
      cos_in = to_unit(c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         q_ff   <= q_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

FILE: src/uvsg_back.sv
`timescale 1ns / 1ps
module uvsg_back #(
   parameter int FRAC = uvsg_pkg::UNIT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  uvsg_pkg::item_type in_item,
   input  logic [15:0]        radius,
   output logic               out_valid,
   output uvsg_pkg::rsp_type  out_rsp
);
   localparam int U   = FRAC + 2;
   localparam int PW  = (2 * U > U + 17) ? 2 * U : U + 17;
   localparam int CL  = uvsg_pkg::CORDIC_STEPS + 1;
   localparam int LAT = CL + 4;

   logic signed [U-1:0]  sp;
   logic signed [U-1:0]  cp;
   logic signed [U-1:0]  stt;
   logic signed [U-1:0]  ct;
   logic signed [16:0]   r_s;
   logic [LAT-1:0]       vld_ff;
   uvsg_pkg::side_type   side_ff [LAT-1];

   logic signed [2*U-1:0] mx1_ff;
   logic signed [2*U-1:0] mz1_ff;
   logic signed [U+16:0]  my1_ff;
   logic signed [U-1:0]   ux2_ff;
   logic signed [U-1:0]   ux2_in;
   logic signed [U-1:0]   uz2_ff;
   logic signed [U-1:0]   uz2_in;
   logic signed [16:0]    py2_ff;
   logic signed [16:0]    py2_in;
   logic signed [U+16:0]  mx3_ff;
   logic signed [U+16:0]  mz3_ff;
   logic signed [16:0]    py3_ff;
   uvsg_pkg::rsp_type     rsp_ff;
   uvsg_pkg::rsp_type     rsp_in;

   // divide by 2^FRAC, round to nearest, ties away from zero
   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
      logic [PW:0] mag;
      logic [PW:0] m;
      mag = v[PW-1] ? (PW+1)'(-{v[PW-1], v}) : {1'b0, v};
      m   = (PW+1)'((mag + (PW+1)'(1 << (FRAC - 1))) >> FRAC);
      return v[PW-1] ? PW'(-m) : PW'(m);
   endfunction

   uvsg_cordic #(.FRAC(FRAC)) u_phi_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (in_item.phi),
      .sin_out (sp),
      .cos_out (cp)
   );

   uvsg_cordic #(.FRAC(FRAC)) u_theta_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (in_item.theta),
      .sin_out (stt),
      .cos_out (ct)
   );

   assign r_s = signed'({1'b0, radius});

   always_comb begin
      logic signed [PW-1:0] t;
      t      = rnd(PW'(mx1_ff));
      ux2_in = t[U-1:0];
      t      = rnd(PW'(mz1_ff));
      uz2_in = t[U-1:0];
      t      = rnd(PW'(my1_ff));
      py2_in = t[16:0];
   end

   always_comb begin
      logic signed [PW-1:0] t;
      uvsg_pkg::side_type   sd;
      sd = side_ff[LAT-2];
      t  = rnd(PW'(mx3_ff));
      rsp_in.pos_x = t[16:0];
      t  = rnd(PW'(mz3_ff));
      rsp_in.pos_z = t[16:0];
      rsp_in.pos_y = py3_ff;
      rsp_in.vertex_number = sd.k;
      rsp_in.quad_valid    = sd.quad;
      if (sd.quad) begin
         rsp_in.tri_one_a = sd.k;
         rsp_in.tri_one_b = 16'(sd.k + 16'(sd.w) + 16'd1);
         rsp_in.tri_one_c = 16'(sd.k + 16'(sd.w));
         rsp_in.tri_two_a = 16'(sd.k + 16'(sd.w) + 16'd1);
         rsp_in.tri_two_b = sd.k;
         rsp_in.tri_two_c = 16'(sd.k + 16'd1);
      end else begin
         rsp_in.tri_one_a = '0;
         rsp_in.tri_one_b = '0;
         rsp_in.tri_one_c = '0;
         rsp_in.tri_two_a = '0;
         rsp_in.tri_two_b = '0;
         rsp_in.tri_two_c = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_item.side;
         for (int s = 1; s < LAT - 1; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         mx1_ff <= ct * sp;
         mz1_ff <= stt * sp;
         my1_ff <= r_s * cp;
         ux2_ff <= ux2_in;
         uz2_ff <= uz2_in;
         py2_ff <= py2_in;
         mx3_ff <= r_s * ux2_ff;
         mz3_ff <= r_s * uz2_ff;
         py3_ff <= py2_ff;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_rsp   = rsp_ff;
endmodule

FILE: src/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// throughput: one grid point per cycle unless rsp_tready back-pressure stalls the pipelines,
// set by the 40-stage angle dividers and the 30-step pipelined cordic units
// reset: radius 256 (1.0), slice and stack counts 16; pipelines and queue emptied
module uv_sphere_vertex_generator #(
   parameter int UNIT_FRAC_BITS = uvsg_pkg::UNIT_FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // stack_index, slice_index
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [167:0]  rsp_tdata,   // pos_x, pos_y, pos_z, vertex_number, tri_one_a,
                                      // tri_one_b, tri_one_c, tri_two_a, tri_two_b,
                                      // tri_two_c, zero pad
   output logic [0:0]    rsp_tuser,   // quad_valid
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);
   uvsg_pkg::cfg_type  cfg_ff;
   logic               front_en;
   logic               back_en;
   logic               front_valid;
   uvsg_pkg::item_type front_item;
   uvsg_pkg::item_type head;
   logic               q_not_empty;
   logic               q_has_space;
   uvsg_pkg::rsp_type  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius <= 16'd256;
         cfg_ff.slices <= 8'd16;
         cfg_ff.stacks <= 8'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            uvsg_pkg::REG_RADIUS: cfg_ff.radius <= csr_data;
            uvsg_pkg::REG_SLICES: cfg_ff.slices <= csr_data[7:0];
            uvsg_pkg::REG_STACKS: cfg_ff.stacks <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign front_en   = q_has_space;
   assign req_tready = front_en;
   assign back_en    = !rsp_tvalid || rsp_tready;

   uvsg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (front_en),
      .in_valid    (req_tvalid),
      .stack_index (req_tdata[7:0]),
      .slice_index (req_tdata[15:8]),
      .cfg         (cfg_ff),
      .out_valid   (front_valid),
      .out_item    (front_item)
   );

   uvsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_en && front_valid),
      .push_item (front_item),
      .pop       (back_en && q_not_empty),
      .head      (head),
      .not_empty (q_not_empty),
      .has_space (q_has_space)
   );

   uvsg_back #(.FRAC(UNIT_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (q_not_empty),
      .in_item   (head),
      .radius    (cfg_ff.radius),
      .out_valid (rsp_tvalid),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.tri_two_c, rsp.tri_two_b, rsp.tri_two_a,
                       rsp.tri_one_c, rsp.tri_one_b, rsp.tri_one_a,
                       rsp.vertex_number, rsp.pos_z, rsp.pos_y, rsp.pos_x};
   assign rsp_tuser = rsp.quad_valid;
endmodule

FILE: dv/tb_uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
module tb_uv_sphere_vertex_generator;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 400000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [15:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [167:0]  rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_valid;
   logic          csr_ready;
   logic [1:0]    csr_index;
   logic [15:0]   csr_data;

   uv_sphere_vertex_generator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   logic [15:0]       grid_points [$];
   uvsg_pkg::rsp_type expected_vertices [$];
   logic [15:0] cur_radius;
   logic [7:0]  cur_slices;
   logic [7:0]  cur_stacks;
   int          errors;
   int          cycles;
   int          req_gap;
   int          rsp_stall;
   bit          req_taken;
   bit          csr_taken;
   bit          quiet;

   function automatic longint round_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >> s;
      return -((-v + half) >> s);
   endfunction

   function automatic int clamp_count(logic [7:0] c);
      if (c == 0) return 1;
      if (int'(c) > uvsg_pkg::MAX_SEGMENTS) return uvsg_pkg::MAX_SEGMENTS;
      return int'(c);
   endfunction

   function automatic logic [31:0] angle_of(int num, int den);
      longint unsigned n;
      n = longint'(num % den);
      return 32'(((n << 32) + longint'(den / 2)) / longint'(den));
   endfunction

   function automatic void rotate(logic [31:0] a, output longint s_unit, output longint c_unit);
      longint x, y, z, nx, c, s, one;
      x = 652032874;
      y = 0;
      z = longint'(a[29:0]);
      for (int k = 0; k < uvsg_pkg::CORDIC_STEPS; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z = z - longint'(uvsg_pkg::ATAN_TURN[k]);
         end else begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z = z + longint'(uvsg_pkg::ATAN_TURN[k]);
         end
         x = nx;
      end
      case (a[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      one = longint'(1) << uvsg_pkg::UNIT_FRAC_BITS;
      s_unit = round_shift(s, 30 - uvsg_pkg::UNIT_FRAC_BITS);
      c_unit = round_shift(c, 30 - uvsg_pkg::UNIT_FRAC_BITS);
      if (s_unit > one) s_unit = one;
      if (s_unit < -one) s_unit = -one;
      if (c_unit > one) c_unit = one;
      if (c_unit < -one) c_unit = -one;
   endfunction

   function automatic uvsg_pkg::rsp_type vertex_of(logic [7:0] i, logic [7:0] j);
      uvsg_pkg::rsp_type v;
      int sl, st, w;
      logic [15:0] k;
      longint sp, cp, stt, ct, r;
      sl = clamp_count(cur_slices);
      st = clamp_count(cur_stacks);
      w = sl + 1;
      k = 16'(int'(i) * w + int'(j));
      r = longint'(cur_radius);
      rotate(angle_of(int'(i), 2 * st), sp, cp);
      rotate(angle_of(int'(j), sl), stt, ct);
      v = '0;
      v.pos_y = 17'(round_shift(r * cp, uvsg_pkg::UNIT_FRAC_BITS));
      v.pos_x = 17'(round_shift(r * round_shift(ct * sp, uvsg_pkg::UNIT_FRAC_BITS),
                                uvsg_pkg::UNIT_FRAC_BITS));
      v.pos_z = 17'(round_shift(r * round_shift(stt * sp, uvsg_pkg::UNIT_FRAC_BITS),
                                uvsg_pkg::UNIT_FRAC_BITS));
      v.vertex_number = k;
      v.quad_valid = (int'(i) < st) && (int'(j) < sl);
      if (v.quad_valid) begin
         v.tri_one_a = k;
         v.tri_one_b = 16'(k + w + 1);
         v.tri_one_c = 16'(k + w);
         v.tri_two_a = 16'(k + w + 1);
         v.tri_two_b = k;
         v.tri_two_c = 16'(k + 1);
      end
      return v;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // monitor
   always @(posedge clock) begin
      uvsg_pkg::rsp_type got, want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("uv_sphere_vertex_generator: mismatch");
         $finish;
      end
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               uvsg_pkg::REG_RADIUS: cur_radius = csr_data;
               uvsg_pkg::REG_SLICES: cur_slices = csr_data[7:0];
               uvsg_pkg::REG_STACKS: cur_stacks = csr_data[7:0];
               default: ;
            endcase
            csr_taken = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            expected_vertices.insert(expected_vertices.size(),
                                     vertex_of(req_tdata[7:0], req_tdata[15:8]));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.pos_x = rsp_tdata[16:0];
            got.pos_y = rsp_tdata[33:17];
            got.pos_z = rsp_tdata[50:34];
            got.vertex_number = rsp_tdata[66:51];
            got.tri_one_a = rsp_tdata[82:67];
            got.tri_one_b = rsp_tdata[98:83];
            got.tri_one_c = rsp_tdata[114:99];
            got.tri_two_a = rsp_tdata[130:115];
            got.tri_two_b = rsp_tdata[146:131];
            got.tri_two_c = rsp_tdata[162:147];
            got.quad_valid = rsp_tuser[0];
            if (expected_vertices.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               want = expected_vertices.pop_front();
               if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
               if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
               if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
               if (got.vertex_number !== want.vertex_number)
                  report("vertex_number", got.vertex_number, want.vertex_number);
               if (got.quad_valid !== want.quad_valid)
                  report("quad_valid", got.quad_valid, want.quad_valid);
               if (got.tri_one_a !== want.tri_one_a)
                  report("tri_one_a", got.tri_one_a, want.tri_one_a);
               if (got.tri_one_b !== want.tri_one_b)
                  report("tri_one_b", got.tri_one_b, want.tri_one_b);
               if (got.tri_one_c !== want.tri_one_c)
                  report("tri_one_c", got.tri_one_c, want.tri_one_c);
               if (got.tri_two_a !== want.tri_two_a)
                  report("tri_two_a", got.tri_two_a, want.tri_two_a);
               if (got.tri_two_b !== want.tri_two_b)
                  report("tri_two_b", got.tri_two_b, want.tri_two_b);
               if (got.tri_two_c !== want.tri_two_c)
                  report("tri_two_c", got.tri_two_c, want.tri_two_c);
               if (rsp_tdata[167:163] !== '0) report("pad", rsp_tdata[167:163], 0);
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (grid_points.size() > 0) begin
               req_tdata <= grid_points.pop_front();
               req_tvalid <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      csr_taken = 1'b0;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      csr_taken = 1'b0;
   endtask

   task automatic set_sphere(logic [15:0] r, logic [7:0] sl, logic [7:0] st);
      write_reg(uvsg_pkg::REG_RADIUS, r);
      write_reg(uvsg_pkg::REG_SLICES, {8'($urandom_range(0, 255)), sl});
      write_reg(uvsg_pkg::REG_STACKS, {8'($urandom_range(0, 255)), st});
   endtask

   task automatic add_point(int i, int j);
      grid_points.insert(grid_points.size(), {8'(j), 8'(i)});
   endtask

   task automatic random_points(int n);
      int sl, st;
      sl = clamp_count(cur_slices);
      st = clamp_count(cur_stacks);
      for (int p = 0; p < n; p++) begin
         if ($urandom_range(0, 9) < 8)
            add_point($urandom_range(0, st), $urandom_range(0, sl));
         else
            add_point($urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   task automatic drain();
      while (grid_points.size() > 0 || req_tvalid || expected_vertices.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      req_gap = 0;
      rsp_stall = 0;
      req_taken = 1'b0;
      csr_taken = 1'b0;
      quiet = 1'b0;
      cur_radius = 16'd256;
      cur_slices = 8'd16;
      cur_stacks = 8'd16;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = uvsg_pkg::REG_RADIUS;
      csr_data = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // poles, seam, corners of the grid and points past the grid
      add_point(0, 0);
      add_point(16, 16);
      add_point(8, 4);
      add_point(15, 15);
      add_point(16, 0);
      add_point(0, 16);
      add_point(17, 3);
      add_point(32, 17);
      add_point(255, 255);
      add_point(255, 0);
      add_point(0, 255);
      add_point(170, 85);
      add_point(85, 170);
      drain();

      write_reg(REG_UNUSED, 16'hffff);
      set_sphere(16'hffff, 8'd255, 8'd255);
      add_point(0, 0);
      add_point(255, 255);
      add_point(254, 254);
      add_point(127, 64);
      add_point(128, 191);
      random_points(110);
      drain();

      quiet = 1'b1;
      set_sphere(16'h0000, 8'd0, 8'd0);
      add_point(0, 0);
      add_point(1, 1);
      add_point(2, 0);
      random_points(60);
      drain();
      quiet = 1'b0;

      set_sphere(16'h0001, 8'd1, 8'd1);
      random_points(80);
      drain();

      set_sphere(16'h0100, 8'd3, 8'd2);
      random_points(100);
      drain();

      write_reg(REG_UNUSED, 16'h1234);
      random_points(60);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         quiet = (ph == 2);
         set_sphere(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
         random_points(75);
         drain();
      end

      if (errors == 0) begin
         $display("uv_sphere_vertex_generator: match");
      end else begin
         $display("uv_sphere_vertex_generator: mismatch");
      end
      $finish;
   end

endmodule
